FILE: rtl/spc_pkg.sv
// package: sizes, codes and types shared by the positive cycle detector
package spc_pkg;

  localparam int unsigned MAX_VERTICES = 512;
  localparam int unsigned MAX_EDGES    = 512;

  localparam int unsigned VTX_W  = $clog2(MAX_VERTICES);
  localparam int unsigned EDGE_W = $clog2(MAX_EDGES);
  localparam int unsigned EP_W   = EDGE_W + 1;
  localparam int unsigned QLEN_W = VTX_W + 1;

  localparam int unsigned AMT_W  = 48;
  localparam int unsigned HOP_W  = 10;
  localparam int unsigned RATE_W = 24;
  localparam int unsigned COMM_W = 32;

  localparam int unsigned VREC_W = AMT_W + HOP_W + 1;
  localparam int unsigned EREC_W = EP_W + VTX_W + RATE_W + COMM_W;

  typedef logic signed [AMT_W-1:0] amount_t;

  localparam amount_t INIT_AMOUNT = -amount_t'(100 * 65536);
  localparam amount_t AMOUNT_MAX  = {1'b0, {(AMT_W-1){1'b1}}};
  localparam amount_t AMOUNT_MIN  = {1'b1, {(AMT_W-1){1'b0}}};

  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_CYCLE    = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_START_VERTEX = 2'd1;
  localparam logic [1:0] CFG_START_AMOUNT = 2'd2;

endpackage

FILE: rtl/spc_ram.sv
// generic single write port ram with registered read
module spc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/spc_exchange.sv
// exchange unit: (amount - commission) * rate over two passes of one shared multiplier
module spc_exchange (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  spc_pkg::amount_t                amount_i,
  input  logic [spc_pkg::COMM_W-1:0]      commission_i,
  input  logic [spc_pkg::RATE_W-1:0]      rate_i,
  output spc_pkg::amount_t                result_o
);
  import spc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_OUT  = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [AMT_W-1:0]  mag_q;
  logic              neg_q;
  logic [RATE_W-1:0] rate_q;
  logic [47:0]       plo_q, phi_q, prod;
  logic [AMT_W:0]    diff, diff_abs;
  logic [23:0]       op;
  logic [56:0]       q_sum;

  assign diff     = {amount_i[AMT_W-1], amount_i} - {{(AMT_W+1-COMM_W){1'b0}}, commission_i};
  assign diff_abs = diff[AMT_W] ? -diff : diff;

  assign op   = (phase_q == PH_LO) ? mag_q[23:0] : mag_q[47:24];
  assign prod = {24'b0, op} * {24'b0, rate_q};

  always_comb begin
    phase_d = phase_q;
    if (start_i) begin
      phase_d = PH_LO;
    end else if (phase_q == PH_LO) begin
      phase_d = PH_HI;
    end else if (phase_q == PH_HI) begin
      phase_d = PH_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= diff_abs[AMT_W-1:0];
      neg_q  <= diff[AMT_W];
      rate_q <= rate_i;
    end
    if (phase_q == PH_LO) begin
      plo_q <= prod;
    end
    if (phase_q == PH_HI) begin
      phi_q <= prod;
    end
  end

  assign q_sum = {1'b0, phi_q, 8'b0} + {25'b0, plo_q[47:16]};

  always_comb begin
    if (!neg_q) begin
      result_o = (q_sum > {9'b0, AMOUNT_MAX}) ? AMOUNT_MAX : amount_t'(q_sum[AMT_W-1:0]);
    end else if (q_sum[56:AMT_W-1] != '0) begin
      result_o = AMOUNT_MIN;
    end else begin
      result_o = -amount_t'(q_sum[AMT_W-1:0]);
    end
  end

endmodule

FILE: rtl/spfa_positive_cycle_detect.sv
// positive exchange cycle detector: edge store plus queue based relaxation
// an edge is stored in the load state; a non-last edge then frees the input
// a search inits every vertex record and seeds the start vertex, then pops and scans edges
// every verdict is followed by a clear of every edge list head before input is taken
// after reset the same clear runs; config writes are taken at all times
module spfa_positive_cycle_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [8:0]                    from_vertex_i,
  input  logic [8:0]                    to_vertex_i,
  input  logic [spc_pkg::RATE_W-1:0]    rate_i,
  input  logic [spc_pkg::COMM_W-1:0]    commission_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    verdict_o
);
  import spc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_SEED  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_POPW  = 4'd6;
  localparam logic [3:0] S_FETCH = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_EX1   = 4'd10;
  localparam logic [3:0] S_EX2   = 4'd11;
  localparam logic [3:0] S_EX3   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [VTX_W-1:0]  cnt_q, cnt_d;
  logic [EP_W-1:0]   ecnt_q, ecnt_d;
  logic              ovf_q, ovf_d;
  logic [VTX_W-1:0]  head_q, head_d;
  logic [QLEN_W-1:0] len_q, len_d;
  logic [1:0]        pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        verdict_q, verdict_d;

  logic [8:0]        vc_q, sv_q;
  logic [31:0]       sa_q;

  logic [VTX_W-1:0]  from_q, to_q;
  logic [RATE_W-1:0] rate_q;
  logic [COMM_W-1:0] comm_q;
  logic              last_q;

  logic [VTX_W-1:0]  t_q, t_d, j_q, j_d;
  amount_t           amt_t_q, amt_t_d, amt_j_q, amt_j_d;
  logic [HOP_W-1:0]  hop_t_q, hop_t_d;
  logic              qd_j_q, qd_j_d;
  logic [EP_W-1:0]   e_q, e_d;

  logic              lh_we;
  logic [VTX_W-1:0]  lh_waddr, lh_raddr;
  logic [EP_W-1:0]   lh_wdata, lh_rdata;
  logic              er_we;
  logic [EDGE_W-1:0] er_waddr, er_raddr;
  logic [EREC_W-1:0] er_wdata, er_rdata;
  logic              vx_we;
  logic [VTX_W-1:0]  vx_waddr, vx_raddr;
  logic [VREC_W-1:0] vx_wdata, vx_rdata;
  logic              wq_we;
  logic [VTX_W-1:0]  wq_waddr, wq_raddr, wq_wdata, wq_rdata;

  logic              ex_start;
  amount_t           ex_result;
  logic [HOP_W-1:0]  hop_new;
  logic [EP_W-1:0]   er_next;
  logic [VTX_W-1:0]  er_target;
  logic [RATE_W-1:0] er_rate;
  logic [COMM_W-1:0] er_comm;

  assign {er_next, er_target, er_rate, er_comm} = er_rdata;
  assign hop_new = hop_t_q + HOP_W'(1);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  spc_ram #(.WIDTH(EP_W), .DEPTH(MAX_VERTICES)) u_list_head (
    .clk_i(clk_i), .we_i(lh_we), .waddr_i(lh_waddr), .wdata_i(lh_wdata),
    .raddr_i(lh_raddr), .rdata_o(lh_rdata)
  );

  spc_ram #(.WIDTH(EREC_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk_i(clk_i), .we_i(er_we), .waddr_i(er_waddr), .wdata_i(er_wdata),
    .raddr_i(er_raddr), .rdata_o(er_rdata)
  );

  spc_ram #(.WIDTH(VREC_W), .DEPTH(MAX_VERTICES)) u_vertices (
    .clk_i(clk_i), .we_i(vx_we), .waddr_i(vx_waddr), .wdata_i(vx_wdata),
    .raddr_i(vx_raddr), .rdata_o(vx_rdata)
  );

  spc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue (
    .clk_i(clk_i), .we_i(wq_we), .waddr_i(wq_waddr), .wdata_i(wq_wdata),
    .raddr_i(wq_raddr), .rdata_o(wq_rdata)
  );

  spc_exchange u_exchange (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(ex_start), .amount_i(amt_t_q),
    .commission_i(er_comm), .rate_i(er_rate), .result_o(ex_result)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    ovf_d       = ovf_q;
    head_d      = head_q;
    len_d       = len_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    verdict_d   = verdict_q;
    t_d         = t_q;
    j_d         = j_q;
    amt_t_d     = amt_t_q;
    amt_j_d     = amt_j_q;
    hop_t_d     = hop_t_q;
    qd_j_d      = qd_j_q;
    e_d         = e_q;

    lh_we    = 1'b0;
    lh_waddr = cnt_q;
    lh_wdata = EP_W'(MAX_EDGES);
    lh_raddr = from_vertex_i;
    er_we    = 1'b0;
    er_waddr = ecnt_q[EDGE_W-1:0];
    er_wdata = {lh_rdata, to_q, rate_q, comm_q};
    er_raddr = e_q[EDGE_W-1:0];
    vx_we    = 1'b0;
    vx_waddr = cnt_q;
    vx_wdata = {INIT_AMOUNT, HOP_W'(0), 1'b0};
    vx_raddr = er_target;
    wq_we    = 1'b0;
    wq_waddr = head_q + len_q[VTX_W-1:0];
    wq_wdata = j_q;
    wq_raddr = head_q;
    ex_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (ecnt_q == EP_W'(MAX_EDGES)) begin
          ovf_d = 1'b1;
        end else begin
          er_we    = 1'b1;
          lh_we    = 1'b1;
          lh_waddr = from_q;
          lh_wdata = ecnt_q;
          ecnt_d   = ecnt_q + EP_W'(1);
        end
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (ovf_q || ecnt_q == EP_W'(MAX_EDGES)) begin
          pend_d  = VERDICT_OVERFLOW;
          state_d = S_DONE;
        end else begin
          cnt_d   = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        vx_we = 1'b1;
        cnt_d = cnt_q + VTX_W'(1);
        if (cnt_q == VTX_W'(MAX_VERTICES - 1)) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        vx_we    = 1'b1;
        vx_waddr = sv_q;
        vx_wdata = {amount_t'({16'b0, sa_q}), HOP_W'(0), 1'b1};
        wq_we    = 1'b1;
        wq_waddr = '0;
        wq_wdata = sv_q;
        head_d   = '0;
        len_d    = QLEN_W'(1);
        state_d  = S_POP;
      end
      S_POP: begin
        if (len_q == '0) begin
          pend_d  = VERDICT_NONE;
          state_d = S_DONE;
        end else begin
          head_d  = head_q + VTX_W'(1);
          len_d   = len_q - QLEN_W'(1);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        t_d      = wq_rdata;
        vx_raddr = wq_rdata;
        lh_raddr = wq_rdata;
        state_d  = S_FETCH;
      end
      S_FETCH: begin
        amt_t_d  = amount_t'(vx_rdata[VREC_W-1:HOP_W+1]);
        hop_t_d  = vx_rdata[HOP_W:1];
        e_d      = lh_rdata;
        vx_we    = 1'b1;
        vx_waddr = t_q;
        vx_wdata = {vx_rdata[VREC_W-1:1], 1'b0};
        state_d  = S_EDGE;
      end
      S_EDGE: begin
        if (e_q == EP_W'(MAX_EDGES)) begin
          state_d = S_POP;
        end else begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        j_d      = er_target;
        e_d      = er_next;
        ex_start = 1'b1;
        state_d  = S_EX1;
      end
      S_EX1: begin
        amt_j_d = amount_t'(vx_rdata[VREC_W-1:HOP_W+1]);
        qd_j_d  = vx_rdata[0];
        state_d = S_EX2;
      end
      S_EX2: begin
        state_d = S_EX3;
      end
      S_EX3: begin
        state_d = S_EDGE;
        if (ex_result > amt_j_q) begin
          if (hop_new >= {1'b0, vc_q}) begin
            pend_d  = VERDICT_CYCLE;
            state_d = S_DONE;
          end else begin
            vx_we    = 1'b1;
            vx_waddr = j_q;
            vx_wdata = {ex_result, hop_new, 1'b1};
            if (!qd_j_q) begin
              wq_we = 1'b1;
              len_d = len_q + QLEN_W'(1);
            end
            if (j_q == t_q) begin
              amt_t_d = ex_result;
              hop_t_d = hop_new;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          verdict_d   = pend_q;
          cnt_d       = '0;
          state_d     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        lh_we = 1'b1;
        cnt_d = cnt_q + VTX_W'(1);
        if (cnt_q == VTX_W'(MAX_VERTICES - 1)) begin
          ecnt_d  = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      ovf_q       <= 1'b0;
      head_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      vc_q        <= 9'd1;
      sv_q        <= 9'd1;
      sa_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ecnt_q      <= ecnt_d;
      ovf_q       <= ovf_d;
      head_q      <= head_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_VERTEX_COUNT: vc_q <= cfg_data_i[8:0];
          CFG_START_VERTEX: sv_q <= cfg_data_i[8:0];
          CFG_START_AMOUNT: sa_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
      rate_q <= rate_i;
      comm_q <= commission_i;
      last_q <= last_edge_i;
    end
    pend_q    <= pend_d;
    verdict_q <= verdict_d;
    t_q       <= t_d;
    j_q       <= j_d;
    amt_t_q   <= amt_t_d;
    amt_j_q   <= amt_j_d;
    hop_t_q   <= hop_t_d;
    qd_j_q    <= qd_j_d;
    e_q       <= e_d;
  end

endmodule
